/* rtl/core/sfrl_pkg.sv */
// Shared types, constants and hash helpers for the sketch rate limiter.
package sfrl_pkg;
    localparam int ROWS = 3;
    localparam int BUCKETS_PER_ROW = 1024;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SLOT_W = $clog2(BUCKETS_PER_ROW);
    localparam int ADDR_W = $clog2(ROWS * BUCKETS_PER_ROW);
    localparam int DEPTH = ROWS * BUCKETS_PER_ROW;
    localparam int BKT_W = 50;
    localparam int CLK_W = 48;
    localparam int Q_DEPTH = 2;

    localparam logic [1:0] REG_BURST = 2'd0;
    localparam logic [1:0] REG_RATE  = 2'd1;
    localparam logic [1:0] REG_SEED  = 2'd2;

    typedef struct packed {
        logic [ROWS-1:0][SLOT_W-1:0] slot;
        logic [15:0]                 size;
        logic [CLK_W-1:0]            clk;
    } t_job;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int r);
        rotl = (v << r) | (v >> (32 - r));
    endfunction
endpackage

/* rtl/core/sfrl_front.sv */
// Front end: hash pipeline and virtual clock, one beat per cycle unless stalled by a full queue.
module sfrl_front
    import sfrl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_flow_key,
    input  logic [15:0] i_packet_size,
    input  logic [31:0] i_arrival_time,
    input  logic [31:0] i_rate,
    input  logic [31:0] i_seed,
    input  logic        i_q_full,
    output logic        o_push,
    output t_job        o_job
);
    // stage 1: k*c1, rate*time; stage 2: k2*c2 and h mix; stage 3: *fm1; stage 4: *fm2
    logic [3:0] r_v;
    logic [31:0] r_k1;
    logic [63:0] r_prod;
    logic [ROWS-1:0][31:0] r_h2, r_h3, r_h4;
    logic [15:0] r_sz1, r_sz2, r_sz3, r_sz4;
    logic [CLK_W-1:0] r_c2, r_c3, r_c4;
    logic [31:0] r_seed1;
    logic adv;
    logic [ROWS-1:0][31:0] n_h2, n_h3;
    logic [31:0] k1r, k2;

    // pipeline advances only when last stage drains or is empty
    assign adv = !(r_v[3] && i_q_full);
    assign o_stall = !adv;
    assign o_push = r_v[3] && !i_q_full;

    always_comb begin
        logic [31:0] h, t;
        k1r = rotl(r_k1, 15);
        k2 = k1r * 32'h1b873593;
        for (int i = 0; i < ROWS; i++) begin
            h = (r_seed1 + 32'(i)) ^ k2;
            h = rotl(h, 13);
            h = h * 32'd5 + 32'he6546b64;
            h = h ^ 32'd4;
            n_h2[i] = h ^ (h >> 16);
            t = r_h3[i];
            n_h3[i] = t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[2:0], i_valid};
        end
        if (adv) begin
            r_k1 <= i_flow_key * 32'hcc9e2d51;
            r_prod <= 64'(i_rate) * 64'(i_arrival_time);
            r_seed1 <= i_seed;
            r_sz1 <= i_packet_size;
            r_h2 <= n_h2;
            r_c2 <= r_prod[63:16];
            r_sz2 <= r_sz1;
            for (int i = 0; i < ROWS; i++) begin
                r_h3[i] <= r_h2[i] * 32'h85ebca6b;
            end
            r_c3 <= r_c2;
            r_sz3 <= r_sz2;
            for (int i = 0; i < ROWS; i++) begin
                r_h4[i] <= ((r_h3[i] ^ (r_h3[i] >> 13)) * 32'hc2b2ae35);
            end
            r_c4 <= r_c3;
            r_sz4 <= r_sz3;
        end
    end

    // final h ^ (h >> 16), keeping only the bucket bits
    always_comb begin
        for (int i = 0; i < ROWS; i++) begin
            o_job.slot[i] = r_h4[i][SLOT_W-1:0] ^ r_h4[i][16 +: SLOT_W];
        end
        o_job.size = r_sz4;
        o_job.clk = r_c4;
    end
    logic unused;
    assign unused = ^{n_h3, r_h4};
endmodule

/* rtl/core/sfrl_queue.sv */
// Short job queue between front and back ends.
module sfrl_queue
    import sfrl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);
    t_job r_mem [Q_DEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    assign o_full = (r_cnt == 2'(Q_DEPTH));
    assign o_empty = (r_cnt == 2'd0);
    assign o_job = r_mem[r_rp];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) r_mem[r_wp] <= i_job;
    end
endmodule

/* rtl/core/sfrl_back.sv */
// Back end: per-row bucket read, limit check, ordered update, result register.
module sfrl_back
    import sfrl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_job        i_job,
    output logic        o_pop,
    input  logic [31:0] i_burst,
    output logic        o_busy,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_over_limit
);
    typedef enum logic [2:0] {S_CLR, S_IDLE, S_RD, S_CHK, S_WR} t_st;
    t_st r_st;
    logic [BKT_W-1:0] r_mem [DEPTH];
    logic [BKT_W-1:0] r_rd;
    logic [ADDR_W-1:0] r_ca;
    logic [ROW_W-1:0] r_row;
    t_job r_job;
    logic [ROWS-1:0][BKT_W-1:0] r_bl, r_bk;
    logic [BKT_W-1:0] r_least, r_run;
    logic r_valid, r_over;

    logic [ADDR_W-1:0] addr;
    logic [BKT_W-1:0] bl, want, tgt, run_n;
    logic [BKT_W:0] sum;

    assign addr = ADDR_W'(r_row) * ADDR_W'(BUCKETS_PER_ROW) + ADDR_W'(r_job.slot[r_row]);
    assign o_pop = (r_st == S_IDLE) && !i_empty && !(r_valid && i_stall);
    assign o_busy = (r_st != S_IDLE) || r_valid;
    assign o_valid = r_valid;
    assign o_over_limit = r_over;

    always_comb begin
        bl = (r_rd > BKT_W'(r_job.clk)) ? r_rd - BKT_W'(r_job.clk) : '0;
        sum = {1'b0, r_least} + (BKT_W+1)'(r_job.size);
        want = r_bl[r_row] + BKT_W'(r_job.size);
        if (want > BKT_W'(i_burst)) want = BKT_W'(i_burst);
        tgt = want + BKT_W'(r_job.clk);
        run_n = (tgt < r_run) ? tgt : r_run;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR;
            r_ca <= '0;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && !i_stall) r_valid <= 1'b0;
            case (r_st)
                S_CLR: begin
                    r_ca <= r_ca + ADDR_W'(1);
                    if (r_ca == ADDR_W'(DEPTH - 1)) r_st <= S_IDLE;
                end
                S_IDLE: if (o_pop) begin
                    r_job <= i_job;
                    r_row <= '0;
                    r_least <= '1;
                    r_st <= S_RD;
                end
                S_RD: r_st <= S_CHK;
                S_CHK: begin
                    r_bl[r_row] <= bl;
                    r_bk[r_row] <= r_rd;
                    if (bl < r_least) r_least <= bl;
                    if (r_row == ROW_W'(ROWS - 1)) begin
                        r_row <= '0;
                        r_run <= '1;
                        r_st <= S_WR;
                    end else begin
                        r_row <= r_row + ROW_W'(1);
                        r_st <= S_RD;
                    end
                end
                // one row per cycle; rows hit distinct addresses, so the
                // bucket read in the check pass is still current
                S_WR: begin
                    if (sum > (BKT_W+1)'(i_burst)) begin
                        r_over <= 1'b1;
                        r_valid <= 1'b1;
                        r_st <= S_IDLE;
                    end else begin
                        r_run <= run_n;
                        if (r_row == ROW_W'(ROWS - 1)) begin
                            r_over <= 1'b0;
                            r_valid <= 1'b1;
                            r_st <= S_IDLE;
                        end else begin
                            r_row <= r_row + ROW_W'(1);
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[addr];
        if (r_st == S_CLR) r_mem[r_ca] <= '0;
        else if (r_st == S_WR && sum <= (BKT_W+1)'(i_burst) && run_n > r_bk[r_row])
            r_mem[addr] <= run_n;
    end
endmodule

/* rtl/core/sketch_flow_rate_limiter.sv */
// Path from input beat to result: four hash stages, the queue, a read/check pair per
// row, then an update pass over the rows, in which a flagged packet writes nothing.
// The back end's single bucket port sets the packet rate: it pops a new packet only once
// the last is finished; the hash front end takes a beat per cycle while the queue has room.
// Reset: synchronous active low; registers return to defaults and a clearing
// pass over all ROWS*BUCKETS_PER_ROW buckets zeroes the store before the back end takes packets.
module sketch_flow_rate_limiter
    import sfrl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_flow_key,
    input  logic [15:0] i_packet_size,
    input  logic [31:0] i_arrival_time,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_over_limit,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    logic [31:0] r_burst, r_rate, r_seed;
    logic q_full, q_empty, push, pop, busy;
    t_job fj, qj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst <= 32'd65536;
            r_rate <= 32'd65536;
            r_seed <= 32'd2022;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BURST: r_burst <= i_cfg_data;
                REG_RATE: r_rate <= i_cfg_data;
                REG_SEED: r_seed <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sfrl_front u_front (.i_clk, .i_rst_n, .i_valid, .o_stall, .i_flow_key, .i_packet_size,
        .i_arrival_time, .i_rate(r_rate), .i_seed(r_seed), .i_q_full(q_full),
        .o_push(push), .o_job(fj));
    sfrl_queue u_q (.i_clk, .i_rst_n, .i_push(push), .i_job(fj), .o_full(q_full),
        .i_pop(pop), .o_empty(q_empty), .o_job(qj));
    sfrl_back u_back (.i_clk, .i_rst_n, .i_empty(q_empty), .i_job(qj), .o_pop(pop),
        .i_burst(r_burst), .o_busy(busy), .o_valid, .i_stall, .o_over_limit);

    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n) pop |-> !q_empty)
        else $error("pop from empty queue");
    a_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |-> !q_full) else $error("push to full queue");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_over_limit)))
        else $error("result dropped");
    logic unused;
    assign unused = busy;
endmodule
